// File: rtl/core/clock_ratio_operating_point_select_unit_macros.svh
// Assertion macros used by the checker file of the operating point selector.
`ifndef CLOCK_RATIO_OPERATING_POINT_SELECT_UNIT_MACROS_SVH
`define CLOCK_RATIO_OPERATING_POINT_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CROPS_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("crops: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CROPS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("crops: next-cycle check failed");

`endif

// File: rtl/core/crops_pkg.sv
// Package with types, constants, the ratio table and the control store of the selector.
`default_nettype none
package crops_pkg;

	localparam int FREQ_W    = 22;
	localparam int BUS_W     = 16;
	localparam int RATIO_W   = 6;
	localparam int KEEP_W    = 4;
	localparam int CODE_W    = 3;
	localparam int CW_W      = 13;
	localparam int MODE_W    = 2;
	localparam int CNT_W     = 4;
	localparam int PC_W      = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 112;

	localparam logic [BUS_W-1:0]   BUS_FREQ_RST  = 16'd10000;
	localparam logic [RATIO_W-1:0] MAX_RATIO_RST = 6'd60;
	localparam logic [KEEP_W-1:0]  KEEP_RST      = 4'd0;

	localparam logic [RATIO_W-1:0] MIN_RATIO = 6'd20;

	// Code 6 is the 6.0x ratio, code 4 the 2.0x ratio.
	localparam logic [CODE_W-1:0] RESET_CODE  = 3'd6;
	localparam logic [CODE_W-1:0] PSAVE_START = 3'd6;
	localparam logic [CODE_W-1:0] PERF_START  = 3'd4;

	localparam logic [MODE_W-1:0] MODE_POWERSAVE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PERFORMANCE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_BUS_FREQ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_BITS = 2'd2;

	// Bits 12, 10 and 9 of an applied control word are always set.
	localparam logic [CW_W-1:0] CW_FIXED = 13'h1600;

	// Control store addresses.
	localparam logic [PC_W-1:0] UC_IDLE       = 4'd0;
	localparam logic [PC_W-1:0] UC_MUL_LOW    = 4'd1;
	localparam logic [PC_W-1:0] UC_CLAMP_LOW  = 4'd2;
	localparam logic [PC_W-1:0] UC_CLAMP_HIGH = 4'd3;
	localparam logic [PC_W-1:0] UC_ORDER      = 4'd4;
	localparam logic [PC_W-1:0] UC_SCAN_MUL   = 4'd5;
	localparam logic [PC_W-1:0] UC_SCAN_EVAL  = 4'd6;
	localparam logic [PC_W-1:0] UC_CHECK      = 4'd7;
	localparam logic [PC_W-1:0] UC_RAISE      = 4'd8;
	localparam logic [PC_W-1:0] UC_DECIDE     = 4'd9;
	localparam logic [PC_W-1:0] UC_OLD        = 4'd10;
	localparam logic [PC_W-1:0] UC_EMIT       = 4'd11;

	typedef enum logic [2:0] {
		MUL_MIN,
		MUL_MAX,
		MUL_IDX,
		MUL_CUR,
		MUL_SEL,
		MUL_NSEL
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLAMP_LOW,
		OP_CLAMP_HIGH,
		OP_ORDER,
		OP_SCAN,
		OP_RAISE,
		OP_DECIDE,
		OP_OLD,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_WAIT_IN,
		J_LOOP,
		J_SKIP,
		J_GOTO,
		J_EMIT
	} jmp_t;

	typedef struct packed {
		mul_sel_t         mul_sel;
		op_t              op;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		op_t      op;
	} ctrl_t;

	typedef struct packed {
		logic idx_more;
		logic fit_found;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic [BUS_W-1:0]   bus_freq;
		logic [RATIO_W-1:0] max_ratio;
		logic [KEEP_W-1:0]  keep_bits;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        pad;
		logic [MODE_W-1:0] policy_mode;
		logic [FREQ_W-1:0] req_max;
		logic [FREQ_W-1:0] req_min;
	} in_item_t;

	typedef struct packed {
		logic [5:0]        pad;
		logic              ratio_error;
		logic [CW_W-1:0]   control_word;
		logic [FREQ_W-1:0] new_freq;
		logic [FREQ_W-1:0] old_freq;
		logic [CODE_W-1:0] ratio_code;
		logic              applied;
		logic [FREQ_W-1:0] adj_max;
		logic [FREQ_W-1:0] adj_min;
	} out_item_t;

	// Clock ratio times ten for each code.
	function automatic logic [RATIO_W-1:0] ratio_of(input logic [CODE_W-1:0] code);
		case (code)
			3'd0:    ratio_of = 6'd45;
			3'd1:    ratio_of = 6'd50;
			3'd2:    ratio_of = 6'd40;
			3'd3:    ratio_of = 6'd55;
			3'd4:    ratio_of = 6'd20;
			3'd5:    ratio_of = 6'd30;
			3'd6:    ratio_of = 6'd60;
			3'd7:    ratio_of = 6'd35;
			default: ratio_of = 6'd60;
		endcase
	endfunction

	// Microprogram. The scan pass takes two steps per table entry: one to
	// form the product, one to evaluate it.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		case (pc)
			UC_IDLE:       ucode = '{MUL_MIN,  OP_NONE,       J_WAIT_IN, UC_IDLE};
			UC_MUL_LOW:    ucode = '{MUL_MIN,  OP_NONE,       J_NEXT,    UC_IDLE};
			UC_CLAMP_LOW:  ucode = '{MUL_MAX,  OP_CLAMP_LOW,  J_NEXT,    UC_IDLE};
			UC_CLAMP_HIGH: ucode = '{MUL_MAX,  OP_CLAMP_HIGH, J_NEXT,    UC_IDLE};
			UC_ORDER:      ucode = '{MUL_IDX,  OP_ORDER,      J_NEXT,    UC_IDLE};
			UC_SCAN_MUL:   ucode = '{MUL_IDX,  OP_NONE,       J_NEXT,    UC_IDLE};
			UC_SCAN_EVAL:  ucode = '{MUL_IDX,  OP_SCAN,       J_LOOP,    UC_SCAN_MUL};
			UC_CHECK:      ucode = '{MUL_NSEL, OP_NONE,       J_SKIP,    UC_DECIDE};
			UC_RAISE:      ucode = '{MUL_IDX,  OP_RAISE,      J_GOTO,    UC_SCAN_MUL};
			UC_DECIDE:     ucode = '{MUL_CUR,  OP_DECIDE,     J_NEXT,    UC_IDLE};
			UC_OLD:        ucode = '{MUL_SEL,  OP_OLD,        J_NEXT,    UC_IDLE};
			UC_EMIT:       ucode = '{MUL_SEL,  OP_EMIT,       J_EMIT,    UC_EMIT};
			default:       ucode = '{MUL_MIN,  OP_NONE,       J_GOTO,    UC_IDLE};
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/crops_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module crops_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire crops_pkg::stat_t stat,
	output crops_pkg::ctrl_t     ctrl,
	output logic                 idle
);

	logic [crops_pkg::PC_W-1:0] pc_q;
	logic [crops_pkg::PC_W-1:0] pc_d;
	logic [crops_pkg::PC_W-1:0] pc_inc;
	crops_pkg::uword_t          uw;

	assign uw     = crops_pkg::ucode(pc_q);
	assign pc_inc = pc_q + crops_pkg::PC_W'(1);
	assign idle   = (pc_q == crops_pkg::UC_IDLE);

	always_comb begin
		ctrl.mul_sel = uw.mul_sel;
		ctrl.op      = uw.op;
	end

	always_comb begin
		case (uw.jmp)
			crops_pkg::J_NEXT:    pc_d = pc_inc;
			crops_pkg::J_WAIT_IN: pc_d = in_valid ? pc_inc : uw.target;
			crops_pkg::J_LOOP:    pc_d = stat.idx_more ? uw.target : pc_inc;
			crops_pkg::J_SKIP:    pc_d = stat.fit_found ? uw.target : pc_inc;
			crops_pkg::J_GOTO:    pc_d = uw.target;
			crops_pkg::J_EMIT:    pc_d = stat.out_busy ? uw.target : crops_pkg::UC_IDLE;
			default:              pc_d = crops_pkg::UC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= crops_pkg::UC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/crops_dp.sv
// Datapath: window registers, shared multiplier, scan accumulators and output register.
`default_nettype none
module crops_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire crops_pkg::ctrl_t           ctrl,
	input  wire crops_pkg::cfg_t            cfg,
	input  wire logic                       in_fire,
	input  wire logic [crops_pkg::IN_W-1:0] in_data,
	input  wire logic                       m_ready,
	output crops_pkg::stat_t                stat,
	output logic                            m_valid,
	output logic [crops_pkg::OUT_W-1:0]     m_data
);

	crops_pkg::in_item_t  in_item;
	crops_pkg::out_item_t out_d;
	crops_pkg::out_item_t out_q;

	logic [crops_pkg::FREQ_W-1:0]  lo_q, hi_q, prod_q, old_q, prod_d;
	logic [crops_pkg::MODE_W-1:0]  mode_q;
	logic [crops_pkg::CODE_W-1:0]  idx_q, last_q, psel_q, fsel_q, nsel_q, sel_q, cur_q;
	logic [crops_pkg::CNT_W-1:0]   cnt_q;
	logic                          redo_q, applied_q, err_q, m_valid_q;
	logic [crops_pkg::RATIO_W-1:0] opnd, r_idx;
	logic [crops_pkg::CODE_W-1:0]  dec_sel;
	logic                          dec_app, dec_err;
	logic                          bus_nz, fit, ge_lo, out_busy, emit_fire, scan_init;

	assign in_item = crops_pkg::in_item_t'(in_data);
	assign bus_nz  = |cfg.bus_freq;

	// Shared multiplier operand.
	always_comb begin
		case (ctrl.mul_sel)
			crops_pkg::MUL_MIN:  opnd = crops_pkg::MIN_RATIO;
			crops_pkg::MUL_MAX:  opnd = cfg.max_ratio;
			crops_pkg::MUL_IDX:  opnd = crops_pkg::ratio_of(idx_q);
			crops_pkg::MUL_CUR:  opnd = crops_pkg::ratio_of(cur_q);
			crops_pkg::MUL_SEL:  opnd = crops_pkg::ratio_of(sel_q);
			crops_pkg::MUL_NSEL: opnd = crops_pkg::ratio_of(nsel_q);
			default:             opnd = crops_pkg::MIN_RATIO;
		endcase
	end

	assign prod_d = crops_pkg::FREQ_W'(cfg.bus_freq) * crops_pkg::FREQ_W'(opnd);

	assign r_idx     = crops_pkg::ratio_of(idx_q);
	assign fit       = (lo_q <= prod_q) && (hi_q >= prod_q);
	assign ge_lo     = (prod_q >= lo_q);
	assign scan_init = (ctrl.op == crops_pkg::OP_ORDER) || (ctrl.op == crops_pkg::OP_RAISE);
	assign out_busy  = m_valid_q && !m_ready;
	assign emit_fire = (ctrl.op == crops_pkg::OP_EMIT) && !out_busy;

	assign stat.idx_more  = (idx_q != {crops_pkg::CODE_W{1'b1}});
	assign stat.fit_found = (cnt_q != '0) || !bus_nz || redo_q;
	assign stat.out_busy  = out_busy;

	// Selection rule: a single fit wins regardless of mode.
	always_comb begin
		dec_sel = cur_q;
		dec_app = 1'b0;
		dec_err = 1'b0;
		if (cnt_q == crops_pkg::CNT_W'(1)) begin
			dec_sel = last_q;
			dec_app = 1'b1;
		end else begin
			case (mode_q)
				crops_pkg::MODE_POWERSAVE: begin
					dec_sel = psel_q;
					dec_app = 1'b1;
					dec_err = crops_pkg::ratio_of(psel_q) > cfg.max_ratio;
				end
				crops_pkg::MODE_PERFORMANCE: begin
					dec_sel = fsel_q;
					dec_app = 1'b1;
					dec_err = crops_pkg::ratio_of(fsel_q) > cfg.max_ratio;
				end
				default: begin
					dec_sel = cur_q;
				end
			endcase
		end
	end

	always_comb begin
		out_d              = '0;
		out_d.adj_min      = lo_q;
		out_d.adj_max      = hi_q;
		out_d.applied      = applied_q;
		out_d.ratio_code   = sel_q;
		out_d.old_freq     = old_q;
		out_d.new_freq     = prod_q;
		out_d.control_word = applied_q ?
			(crops_pkg::CW_FIXED | {5'b0, sel_q, 1'b0, cfg.keep_bits}) : '0;
		out_d.ratio_error  = err_q;
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (in_fire) begin
			lo_q   <= in_item.req_min;
			hi_q   <= in_item.req_max;
			mode_q <= in_item.policy_mode;
			redo_q <= 1'b0;
		end
		case (ctrl.op)
			crops_pkg::OP_CLAMP_LOW: begin
				if (bus_nz) begin
					if (lo_q < prod_q) lo_q <= prod_q;
					if (hi_q < prod_q) hi_q <= prod_q;
				end
			end
			crops_pkg::OP_CLAMP_HIGH: begin
				if (bus_nz) begin
					if (lo_q > prod_q) lo_q <= prod_q;
					if (hi_q > prod_q) hi_q <= prod_q;
				end
			end
			crops_pkg::OP_ORDER: begin
				if (bus_nz && (lo_q > hi_q)) lo_q <= hi_q;
			end
			crops_pkg::OP_SCAN: begin
				if (fit) begin
					cnt_q  <= cnt_q + crops_pkg::CNT_W'(1);
					last_q <= idx_q;
					if (r_idx < crops_pkg::ratio_of(psel_q)) psel_q <= idx_q;
					if (r_idx > crops_pkg::ratio_of(fsel_q)) fsel_q <= idx_q;
				end
				if (ge_lo && (r_idx < crops_pkg::ratio_of(nsel_q))) nsel_q <= idx_q;
				idx_q <= idx_q + crops_pkg::CODE_W'(1);
			end
			crops_pkg::OP_RAISE: begin
				hi_q   <= prod_q;
				redo_q <= 1'b1;
			end
			crops_pkg::OP_DECIDE: begin
				sel_q     <= dec_sel;
				applied_q <= dec_app;
				err_q     <= dec_err;
			end
			crops_pkg::OP_OLD: begin
				old_q <= prod_q;
			end
			crops_pkg::OP_EMIT: begin
				if (!out_busy) out_q <= out_d;
			end
			default: begin
			end
		endcase
		if (scan_init) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			last_q <= crops_pkg::PERF_START;
			psel_q <= crops_pkg::PSAVE_START;
			fsel_q <= crops_pkg::PERF_START;
			nsel_q <= crops_pkg::PSAVE_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			cur_q     <= crops_pkg::RESET_CODE;
		end else begin
			if (emit_fire) begin
				m_valid_q <= 1'b1;
				cur_q     <= sel_q;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = out_q;

endmodule
`default_nettype wire

// File: rtl/core/clock_ratio_operating_point_select_unit.sv
// Top level of the clock ratio operating point selector.
//
// Requests arrive on the s_axis channel, one transaction per request carrying a
// frequency window and a policy mode. Each request yields exactly one result
// transaction on the m_axis channel with the adjusted window, the selected
// ratio code, the old and new frequency and the clock port control word.
// Settings are written through the cfg channel, which is always ready; write
// it only while the block is idle with no result outstanding.
// A microcoded sequencer steps through a twelve-word program; all products go
// through one shared 16x6 multiplier whose result is registered. Each of the
// eight table entries is scanned by forming its product and then evaluating
// it; when no entry fits the clamped window, the maximum is raised and the
// table is scanned again before the result is produced.
// One request is in flight at a time: s_axis_tready is high only at the first
// step, reached again at the edge that loads the output register, so the next
// request is accepted only after the result of the last one has been loaded.
// When the receiver stalls, the result waits in the output register while the
// next request is processed; the sequencer then holds in its last step.
// Reset sets bus_freq to 10000, max_ratio to 60, the kept control bits to zero
// and the current code to the 6.0x ratio, and leaves the output channel empty.
`default_nettype none
module clock_ratio_operating_point_select_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0 up: req_min[21:0], req_max[43:22], policy_mode[45:44],
	// zero padding [47:46].
	input  wire logic [crops_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// Fields from bit 0 up: adj_min[21:0], adj_max[43:22], applied[44],
	// ratio_code[47:45], old_freq[69:48], new_freq[91:70], control_word[104:92],
	// ratio_error[105], zero padding [111:106].
	output logic [crops_pkg::OUT_W-1:0]           m_axis_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [crops_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [crops_pkg::CFG_DAT_W-1:0]  cfg_data
);

	crops_pkg::cfg_t  cfg_q;
	crops_pkg::ctrl_t ctrl;
	crops_pkg::stat_t stat;
	logic             idle;
	logic             in_fire;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = idle;
	assign in_fire       = s_axis_tvalid && idle;

	// Settings registers; writes to an index past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_freq  <= crops_pkg::BUS_FREQ_RST;
			cfg_q.max_ratio <= crops_pkg::MAX_RATIO_RST;
			cfg_q.keep_bits <= crops_pkg::KEEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				crops_pkg::REG_BUS_FREQ:  cfg_q.bus_freq  <= cfg_data;
				crops_pkg::REG_MAX_RATIO: cfg_q.max_ratio <= cfg_data[crops_pkg::RATIO_W-1:0];
				crops_pkg::REG_KEEP_BITS: cfg_q.keep_bits <= cfg_data[crops_pkg::KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer owns control flow; the datapath reports loop, fit and stall status.
	crops_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.ctrl     (ctrl),
		.idle     (idle)
	);

	crops_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.cfg     (cfg_q),
		.in_fire (in_fire),
		.in_data (s_axis_tdata),
		.m_ready (m_axis_tready),
		.stat    (stat),
		.m_valid (m_axis_tvalid),
		.m_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/core/crops_checker.sv
// Port-level checker for the operating point selector and its bind statement.
`default_nettype none
`include "clock_ratio_operating_point_select_unit_macros.svh"
module crops_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [crops_pkg::OUT_W-1:0]      m_axis_tdata
);

	crops_pkg::out_item_t res;

	assign res = crops_pkg::out_item_t'(m_axis_tdata);

	// A stalled result stays put.
	`CROPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Only one request is processed at a time.
	`CROPS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// Without a selection the control word is zero, no error is flagged and the frequency holds.
	`CROPS_ASSERT_IMPL(a_not_applied, clk, arst_n, m_axis_tvalid && !res.applied, (res.control_word == '0) && !res.ratio_error && (res.new_freq == res.old_freq))

	// A written control word carries its fixed bits and the reported code.
	`CROPS_ASSERT_IMPL(a_word_form, clk, arst_n, m_axis_tvalid && res.applied, res.control_word[12] && !res.control_word[11] && res.control_word[10] && res.control_word[9] && !res.control_word[8] && (res.control_word[7:5] == res.ratio_code) && !res.control_word[4])

endmodule

bind clock_ratio_operating_point_select_unit crops_checker u_crops_checker (.*);
`default_nettype wire
